// ----- rtl/hre_pkg.sv -----
// ----------------------------------------------------------------------------
// hre_pkg
// shared constants, types and sizing functions for the row hamming encoder
// ----------------------------------------------------------------------------
package hre_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROW_BYTES_W = 3;
  localparam int LEN_W       = 6;

  // filler for a row that is cut short by the last byte
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h7E;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // least r with 2^r >= data bits + r + 1
  function automatic int parity_bits(input int nd);
    int r;
    r = 1;
    while ((1 << r) < nd + r + 1) r++;
    return r;
  endfunction

  // widest codeword for a given maximum row size in bytes
  function automatic int cw_width(input int max_bytes);
    return BYTE_W * max_bytes + parity_bits(BYTE_W * max_bytes);
  endfunction

  // bits to hold a row size minus one, at least one bit
  function automatic int sel_width(input int max_bytes);
    return (max_bytes > 1) ? $clog2(max_bytes) : 1;
  endfunction

endpackage

// ----- rtl/hre_front.sv -----
// ----------------------------------------------------------------------------
// hre_front
// byte intake: collects bytes into a row, pads a short last row, queues rows
// ----------------------------------------------------------------------------
module hre_front #(
  parameter int MAX_ROW_BYTES = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_wr_en,
  input  logic [hre_pkg::ROW_BYTES_W-1:0]              cfg_row_bytes,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [hre_pkg::BYTE_W-1:0]                   in_data_byte,
  input  logic                                         in_end_of_text,
  input  hre_pkg::q_status_t                           q_stat,
  output logic                                         q_push,
  output logic [hre_pkg::sel_width(MAX_ROW_BYTES)+
                hre_pkg::BYTE_W*MAX_ROW_BYTES-1:0]     q_push_data
);

  localparam int SEL_W = hre_pkg::sel_width(MAX_ROW_BYTES);
  localparam int ROW_W = hre_pkg::BYTE_W * MAX_ROW_BYTES;

  logic [SEL_W-1:0]                rb_m1_r, rb_m1_nxt;
  logic [SEL_W-1:0]                held_r, held_nxt;
  logic [hre_pkg::BYTE_W-1:0]      row_store_r [MAX_ROW_BYTES];
  logic                            accept;
  logic                            row_done;
  logic [ROW_W-1:0]                row_out;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign row_done = (held_r == rb_m1_r) || in_end_of_text;
  assign q_push   = accept && row_done;
  assign q_push_data = {rb_m1_r, row_out};

  // effective row size, clamped to 1..MAX_ROW_BYTES
  always_comb begin
    rb_m1_nxt = rb_m1_r;
    if (cfg_wr_en) begin
      if (cfg_row_bytes == '0) begin
        rb_m1_nxt = '0;
      end else if (cfg_row_bytes > hre_pkg::ROW_BYTES_W'(MAX_ROW_BYTES)) begin
        rb_m1_nxt = SEL_W'(MAX_ROW_BYTES - 1);
      end else begin
        rb_m1_nxt = SEL_W'(cfg_row_bytes - 1'b1);
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (cfg_wr_en) begin
      held_nxt = '0;
    end else if (accept) begin
      held_nxt = row_done ? '0 : held_r + 1'b1;
    end
  end

  // row as it leaves: held bytes, this byte, pad up to the row size
  always_comb begin
    for (int i = 0; i < MAX_ROW_BYTES; i++) begin
      if (SEL_W'(i) < held_r) begin
        row_out[i*hre_pkg::BYTE_W +: hre_pkg::BYTE_W] = row_store_r[i];
      end else if (SEL_W'(i) == held_r) begin
        row_out[i*hre_pkg::BYTE_W +: hre_pkg::BYTE_W] = in_data_byte;
      end else if (SEL_W'(i) <= rb_m1_r) begin
        row_out[i*hre_pkg::BYTE_W +: hre_pkg::BYTE_W] = hre_pkg::PAD_BYTE;
      end else begin
        row_out[i*hre_pkg::BYTE_W +: hre_pkg::BYTE_W] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_m1_r <= '0;
      held_r  <= '0;
    end else begin
      rb_m1_r <= rb_m1_nxt;
      held_r  <= held_nxt;
    end
  end

  // bytes at or above the count are stale and never read
  always_ff @(posedge clk) begin
    if (accept && !row_done) begin
      row_store_r[held_r] <= in_data_byte;
    end
  end

  a_held_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= rb_m1_r)
    else $error("byte count beyond row size");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_text) |=> (held_r == '0))
    else $error("last byte left a partial row");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("row pushed into a full queue");

endmodule

// ----- rtl/hre_queue.sv -----
// ----------------------------------------------------------------------------
// hre_queue
// two-entry row queue between intake and encoder
// ----------------------------------------------------------------------------
module hre_queue #(
  parameter int WIDTH = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   rd_data,
  output hre_pkg::q_status_t stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign rd_data        = mem_r[rd_ptr_r];
  assign stat.full      = (count_r == 2'd2);
  assign stat.not_empty = (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/hre_back.sv -----
// ----------------------------------------------------------------------------
// hre_back
// encoder: builds the hamming codeword of a queued row into the output register
// ----------------------------------------------------------------------------
module hre_back #(
  parameter int MAX_ROW_BYTES = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  hre_pkg::q_status_t                           q_stat,
  input  logic [hre_pkg::sel_width(MAX_ROW_BYTES)+
                hre_pkg::BYTE_W*MAX_ROW_BYTES-1:0]     q_rd_data,
  output logic                                         q_pop,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [hre_pkg::cw_width(MAX_ROW_BYTES)-1:0]  out_codeword,
  output logic [hre_pkg::LEN_W-1:0]                    out_codeword_length
);

  localparam int SEL_W = hre_pkg::sel_width(MAX_ROW_BYTES);
  localparam int ROW_W = hre_pkg::BYTE_W * MAX_ROW_BYTES;
  localparam int CW_W  = hre_pkg::cw_width(MAX_ROW_BYTES);

  logic [ROW_W-1:0]          row;
  logic [SEL_W-1:0]          rb_m1;
  logic [CW_W-1:0]           cand_cw  [MAX_ROW_BYTES];
  logic [hre_pkg::LEN_W-1:0] cand_len [MAX_ROW_BYTES];

  logic                      valid_r, valid_nxt;
  logic [CW_W-1:0]           cw_r;
  logic [hre_pkg::LEN_W-1:0] len_r;

  assign row   = q_rd_data[ROW_W-1:0];
  assign rb_m1 = q_rd_data[ROW_W +: SEL_W];

  // one encoder per row size; each is a fixed bit map and xor trees
  for (genvar g = 1; g <= MAX_ROW_BYTES; g++) begin : g_enc
    localparam int ND = hre_pkg::BYTE_W * g;
    localparam int NR = hre_pkg::parity_bits(ND);
    localparam int NN = ND + NR;

    logic [CW_W-1:0] cw;

    always_comb begin : enc
      int  j;
      logic p;
      cw = '0;
      j  = 0;
      // data bits msb first into positions that are not powers of two
      for (int pos = 1; pos <= NN; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          cw[pos-1] = row[((j >> 3) << 3) + 7 - (j & 7)];
          j++;
        end
      end
      // even parity at position 2^c over positions with bit c set
      for (int c = 0; c < NR; c++) begin
        p = 1'b0;
        for (int pos = 1; pos <= NN; pos++) begin
          if ((pos & (1 << c)) != 0) p = p ^ cw[pos-1];
        end
        cw[(1 << c) - 1] = p;
      end
    end

    assign cand_cw[g-1]  = cw;
    assign cand_len[g-1] = hre_pkg::LEN_W'(NN);
  end

  assign q_pop     = q_stat.not_empty && (!valid_r || !out_stall);
  assign valid_nxt = q_pop ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cw_r  <= cand_cw[rb_m1];
      len_r <= cand_len[rb_m1];
    end
  end

  assign out_valid           = valid_r;
  assign out_codeword        = cw_r;
  assign out_codeword_length = len_r;

endmodule

// ----- rtl/hamming_row_encoder_top.sv -----
// ----------------------------------------------------------------------------
// hamming_row_encoder_top
// row-wise hamming encoder for a byte stream
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one byte per transfer, in_end_of_text marks the last byte; a short
//           last row is padded with 0x7e before encoding
//   out_* : one codeword per finished row, bit k-1 is codeword position k,
//           bits above out_codeword_length read zero
//   cfg_* : row size in bytes, written with cfg_wr_en while the block is idle;
//           0 acts as 1, values above MAX_ROW_BYTES clamp to it; a write drops
//           any partial row
// throughput: one byte per cycle, sustained, for every row size, while in_stall is low
// path: the row closed by a transferred byte goes into the row queue, then into
//   the encoder register, which drives the codeword on out_*
// reset: rst_n low clears the queue, the output valid and the byte count,
//   row size returns to 1
// receiver stall: the output register holds; the two-entry row queue absorbs
//   rows until full, then in_stall is raised until the encoder drains a row
// ----------------------------------------------------------------------------
module hamming_row_encoder_top #(
  parameter int MAX_ROW_BYTES = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // configuration
  input  logic                                         cfg_wr_en,
  input  logic [hre_pkg::ROW_BYTES_W-1:0]              cfg_row_bytes,
  // byte input
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [hre_pkg::BYTE_W-1:0]                   in_data_byte,
  input  logic                                         in_end_of_text,
  // codeword output
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [hre_pkg::cw_width(MAX_ROW_BYTES)-1:0]  out_codeword,
  output logic [hre_pkg::LEN_W-1:0]                    out_codeword_length
);

  // queue entry: row size minus one above the padded row bytes
  localparam int ENTRY_W = hre_pkg::sel_width(MAX_ROW_BYTES) +
                           hre_pkg::BYTE_W * MAX_ROW_BYTES;

  hre_pkg::q_status_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_push_data;
  logic [ENTRY_W-1:0] q_rd_data;

  // intake: row assembly, padding on the last byte
  hre_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_row_bytes  (cfg_row_bytes),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_text (in_end_of_text),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_push_data    (q_push_data)
  );

  // decouples intake from a stalled output
  hre_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .stat      (q_stat)
  );

  // encoder and output register
  hre_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_rd_data           (q_rd_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_codeword        (out_codeword),
    .out_codeword_length (out_codeword_length)
  );

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the row hamming encoder: a directed table followed
// by random byte streams under several row sizes and idle patterns, every
// codeword checked against a typed table value or an in-bench encoder model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ROW_BYTES = 4;
  localparam int CW_W          = hre_pkg::cw_width(MAX_ROW_BYTES);
  localparam int LEN_W         = hre_pkg::LEN_W;
  localparam int DRAIN_CYCLES  = 4;      // block latency plus margin
  localparam int HOLD_CYCLES   = 150;    // long receiver hold-off
  localparam int SEGMENTS      = 12;
  localparam int SEG_ITEMS     = 94;
  localparam int TIME_LIMIT_NS = 5_000_000;

  // kind of a row in the directed table
  typedef enum logic {
    STEP_BYTE,
    STEP_CFG
  } step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [7:0]             value;     // data byte or row size
    logic                   eot;
    logic                   typed;     // expected codeword given below
    logic [CW_W-1:0]        exp_cw;
    logic [LEN_W-1:0]       exp_len;
  } directed_row_t;

  typedef struct {
    logic [CW_W-1:0]  cw;
    logic [LEN_W-1:0] len;
  } codeword_t;

  localparam int DIRECTED_ROWS = 31;

  // rows: zero and all-ones bytes, the zero and oversized row sizes, a write
  // that drops a partial row, a last byte that closes a row and padded rows
  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{STEP_BYTE, 8'h00, 1'b0, 1'b1, 38'h0,   6'd12},
    '{STEP_BYTE, 8'hFF, 1'b0, 1'b1, 38'hF77, 6'd12},
    '{STEP_BYTE, 8'hA5, 1'b1, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd0,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h3C, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd4,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h12, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h34, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h56, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h78, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h00, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h00, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h00, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h00, 1'b0, 1'b1, 38'h0,   6'd38},
    '{STEP_BYTE, 8'h41, 1'b1, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd7,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h01, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h80, 1'b1, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h55, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd2,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h99, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h66, 1'b1, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd3,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'hC3, 1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h00, 1'b1, 1'b0, 38'h0,   6'd0},
    '{STEP_CFG,  8'd5,  1'b0, 1'b0, 38'h0,   6'd0},
    '{STEP_BYTE, 8'h7E, 1'b1, 1'b0, 38'h0,   6'd0}
  };

  // row size for the first random segments, extremes first
  logic [2:0] segment_row_sizes [0:7] = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6};

  // dut signals, all inputs known from time zero
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_wr_en      = 1'b0;
  logic [2:0]            cfg_row_bytes  = 3'd0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte   = 8'h00;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CW_W-1:0]       out_codeword;
  logic [LEN_W-1:0]      out_codeword_length;

  // encoder model state
  logic [2:0]            row_size_cfg;
  logic [31:0]           row_acc;
  int                    held_cnt;

  codeword_t             pending_codewords [$];
  int                    mismatch_count = 0;

  // idle percentages and long hold-off handshake between processes
  int                    snd_idle_pct   = 30;
  int                    rcv_idle_pct   = 80;
  int                    hold_requested = 0;
  int                    hold_granted   = 0;
  int                    hold_left      = 0;

  hamming_row_encoder_top #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_row_bytes       (cfg_row_bytes),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_codeword        (out_codeword),
    .out_codeword_length (out_codeword_length)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(TIME_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // hamming codeword of the first nbytes bytes of a row, data msb first into
  // the non power-of-two positions, even parity at the powers of two
  function automatic logic [CW_W-1:0] hamming_encode(input logic [31:0] row,
                                                     input int nbytes,
                                                     output int cw_len);
    int nd;
    int r;
    int n;
    int j;
    int pos;
    int c;
    int sh;
    logic par;
    logic [CW_W-1:0] cw;
    nd = 8 * nbytes;
    r  = 1;
    while ((1 << r) < nd + r + 1) r++;
    n  = nd + r;
    cw = '0;
    j  = 0;
    for (pos = 1; pos <= n; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        sh = 8 * (j >> 3) + 7 - (j & 7);
        cw[pos-1] = row[sh];
        j++;
      end
    end
    for (c = 0; c < r; c++) begin
      par = 1'b0;
      for (pos = 1; pos <= n; pos++)
        if ((pos & (1 << c)) != 0) par ^= cw[pos-1];
      cw[(1 << c) - 1] = par;
    end
    cw_len = n;
    return cw;
  endfunction

  // advance the model by one accepted byte and queue the codeword it closes
  task automatic predict_byte(input logic [7:0] d, input logic eot,
                              input logic use_typed, input logic [CW_W-1:0] typed_cw,
                              input logic [LEN_W-1:0] typed_len);
    int rb;
    int idx;
    int i;
    int n;
    codeword_t cw_exp;
    rb = int'(row_size_cfg);
    if (rb < 1) rb = 1;
    if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
    idx = held_cnt;
    if (idx >= rb) idx = rb - 1;
    row_acc[8*idx +: 8] = row_acc[8*idx +: 8] | d;
    if (idx + 1 < rb && !eot) begin
      held_cnt = idx + 1;
      return;
    end
    // short last row gets pad bytes
    for (i = idx + 1; i < rb; i++) row_acc[8*i +: 8] = hre_pkg::PAD_BYTE;
    cw_exp.cw  = hamming_encode(row_acc, rb, n);
    cw_exp.len = n[LEN_W-1:0];
    if (use_typed) begin
      cw_exp.cw  = typed_cw;
      cw_exp.len = typed_len;
    end
    pending_codewords.push_back(cw_exp);
    row_acc  = '0;
    held_cnt = 0;
  endtask

  // random idle cycles before the next byte, valid dropped only once
  task automatic sender_gap();
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < snd_idle_pct) begin
      if (!lowered) in_valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
  endtask

  // offer one byte and wait for its transfer
  task automatic send_byte(input logic [7:0] d, input logic eot,
                           input logic use_typed, input logic [CW_W-1:0] typed_cw,
                           input logic [LEN_W-1:0] typed_len);
    sender_gap();
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(d, eot, use_typed, typed_cw, typed_len);
  endtask

  // row size write, only once every queued codeword is out and the
  // pipeline has had time to settle
  task automatic write_row_size(input logic [2:0] v);
    in_valid <= 1'b0;
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_row_bytes <= v;
    cfg_wr_en     <= 1'b1;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    // a write drops any partial row
    row_size_cfg = v;
    row_acc      = '0;
    held_cnt     = 0;
  endtask

  task automatic log_mismatch(input string what, input logic [CW_W-1:0] e_cw,
                              input logic [LEN_W-1:0] e_len);
    if (mismatch_count < 10)
      $display("mismatch (%s) at %0t: expected cw %h len %0d, got cw %h len %0d",
               what, $realtime, e_cw, e_len, out_codeword, out_codeword_length);
    mismatch_count++;
  endtask

  // receiver: checks every codeword transfer and drives the stall pattern,
  // including the long hold-off when the sender asks for one
  always @(posedge clk) begin
    codeword_t cw_exp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_codewords.size() == 0) begin
          log_mismatch("unexpected", '0, '0);
        end else begin
          cw_exp = pending_codewords.pop_front();
          if (out_codeword !== cw_exp.cw || out_codeword_length !== cw_exp.len)
            log_mismatch("field", cw_exp.cw, cw_exp.len);
        end
      end
      if (hold_granted != hold_requested) begin
        hold_left = HOLD_CYCLES;
        hold_granted++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // stimulus: reset, directed table, random segments, drain and verdict
  initial begin
    int k;
    int seg;
    int item;
    logic [7:0] d;
    logic eot;
    directed_row_t row;

    row_size_cfg = 3'd1;
    row_acc      = '0;
    held_cnt     = 0;

    // synchronous reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, sender idles 30 percent, receiver 80 percent
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      row = directed_rows[k];
      if (row.kind == STEP_CFG)
        write_row_size(row.value[2:0]);
      else
        send_byte(row.value, row.eot, row.typed, row.exp_cw, row.exp_len);
    end

    // random segments: a new row size each, idle pattern by group of four
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin
          snd_idle_pct = 30;
          rcv_idle_pct = 80;
        end
        1: begin
          snd_idle_pct = 80;
          rcv_idle_pct = 30;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      // every segment starts with the sender paused until all codewords are out
      if (seg < 8)
        write_row_size(segment_row_sizes[seg]);
      else
        write_row_size(3'($urandom_range(7)));
      // long receiver hold-off so the row queue fills and input stalls
      if (seg == 3 || seg == 10) hold_requested++;
      for (item = 0; item < SEG_ITEMS; item++) begin
        case ($urandom_range(7))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          2:       d = hre_pkg::PAD_BYTE;
          default: d = 8'($urandom_range(255));
        endcase
        eot = ($urandom_range(5) == 0);
        send_byte(d, eot, 1'b0, '0, '0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);

    if (mismatch_count == 0 && pending_codewords.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
